/* hw/rtl/sis_pkg.sv */
// shared constants, controller states and control bundles for the index shuffle core
`timescale 1ns / 1ps
package sis_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;

  localparam int SEED_W  = 64;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;
  localparam int ENTRY_W = 10;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 16;

  localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam int          SHIFT_A    = 30;
  localparam int          SHIFT_B    = 27;
  localparam int          SHIFT_C    = 31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FILL,
    ST_TOPCHK,
    ST_ADV,
    ST_MUL1,
    ST_XS27,
    ST_MUL2,
    ST_XS31,
    ST_DIV,
    ST_SRA,
    ST_SRB,
    ST_SWA,
    ST_SWB,
    ST_RD,
    ST_RESULT
  } sis_state_t;

  typedef struct packed {
    logic load;
    logic fill_wr;
    logic st_adv;
    logic mul_clr;
    logic mul_step;
    logic mul_b;
    logic xs27;
    logic xs31;
    logic div_step;
    logic rd_top;
    logic rd_pick;
    logic wr_top;
    logic wr_pick;
    logic top_dec;
    logic commit;
    logic rd_pos;
    logic out_load;
  } sis_cmd_t;

  typedef struct packed {
    logic is_read;
    logic pos_bad;
    logic count_bad;
    logic fill_done;
    logic top_le1;
    logic mul_last;
    logic div_last;
    logic out_busy;
  } sis_stat_t;

endpackage

/* hw/rtl/sis_ram.sv */
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module sis_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/sis_ctrl.sv */
// controller state machine sequencing check, fill, mix, modulo, swap, read and result steps
`timescale 1ns / 1ps
module sis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sis_pkg::sis_stat_t stat,
  output sis_pkg::sis_cmd_t  cmd
);
  import sis_pkg::*;

  sis_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (stat.is_read) begin
          state_nxt = stat.pos_bad ? ST_RESULT : ST_RD;
        end else begin
          state_nxt = stat.count_bad ? ST_RESULT : ST_FILL;
        end
      end
      ST_FILL:   if (stat.fill_done) state_nxt = ST_TOPCHK;
      ST_TOPCHK: state_nxt = stat.top_le1 ? ST_RESULT : ST_ADV;
      ST_ADV:    state_nxt = ST_MUL1;
      ST_MUL1:   if (stat.mul_last) state_nxt = ST_XS27;
      ST_XS27:   state_nxt = ST_MUL2;
      ST_MUL2:   if (stat.mul_last) state_nxt = ST_XS31;
      ST_XS31:   state_nxt = ST_DIV;
      ST_DIV:    if (stat.div_last) state_nxt = ST_SRA;
      ST_SRA:    state_nxt = ST_SRB;
      ST_SRB:    state_nxt = ST_SWA;
      ST_SWA:    state_nxt = ST_SWB;
      ST_SWB:    state_nxt = ST_TOPCHK;
      ST_RD:     state_nxt = ST_RESULT;
      ST_RESULT: if (!stat.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FILL:   cmd.fill_wr = !stat.fill_done;
      ST_TOPCHK: cmd.commit = stat.top_le1;
      ST_ADV: begin
        cmd.st_adv  = 1'b1;
        cmd.mul_clr = 1'b1;
      end
      ST_MUL1:   cmd.mul_step = 1'b1;
      ST_XS27: begin
        cmd.xs27    = 1'b1;
        cmd.mul_clr = 1'b1;
      end
      ST_MUL2: begin
        cmd.mul_step = 1'b1;
        cmd.mul_b    = 1'b1;
      end
      ST_XS31:   cmd.xs31 = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_SRA:    cmd.rd_top = 1'b1;
      ST_SRB:    cmd.rd_pick = 1'b1;
      ST_SWA:    cmd.wr_top = 1'b1;
      ST_SWB: begin
        cmd.wr_pick = 1'b1;
        cmd.top_dec = 1'b1;
      end
      ST_RD:     cmd.rd_pos = 1'b1;
      ST_RESULT: cmd.out_load = !stat.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/sis_dpath.sv */
// datapath: generator state, shared 32x32 multiplier, radix-4 modulo, store and result register
`timescale 1ns / 1ps
module sis_dpath #(
  parameter int MAX_ELEMENTS = sis_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sis_pkg::sis_cmd_t            cmd,
  output sis_pkg::sis_stat_t           stat,
  input  logic                         in_cmd,
  input  logic [sis_pkg::SEED_W-1:0]   in_seed,
  input  logic [sis_pkg::COUNT_W-1:0]  in_count,
  input  logic [sis_pkg::POS_W-1:0]    in_pos,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sis_pkg::ENTRY_W-1:0]  out_entry,
  output logic                         out_err
);
  import sis_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic               is_read_r;
  logic [63:0]        state_r;
  logic [63:0]        mix_r;
  logic [63:0]        acc_r;
  logic [1:0]         mul_cnt_r;
  logic [4:0]         div_cnt_r;
  logic [COUNT_W-1:0] rem_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] top_r;
  logic [COUNT_W-1:0] fill_r;
  logic [COUNT_W-1:0] valid_count_r;
  logic [POS_W-1:0]   pos_r;
  logic [AW-1:0]      tmp_r;
  logic               out_valid_r;
  logic [ENTRY_W-1:0] out_entry_r;
  logic               out_err_r;

  logic [63:0]        st_new;
  logic [63:0]        mconst;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [COUNT_W:0]   r1, r1s, r2, r2s;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_wa, ram_ra;
  logic [AW-1:0]      ram_wd, ram_rd;

  assign st_new = state_r + GOLDEN_INC;
  assign mconst = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;

  always_comb begin
    unique case (mul_cnt_r)
      2'd1:    begin mul_a = mix_r[31:0];  mul_b = mconst[63:32]; end
      2'd2:    begin mul_a = mix_r[63:32]; mul_b = mconst[31:0];  end
      default: begin mul_a = mix_r[31:0];  mul_b = mconst[31:0];  end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  // two remainder bits per cycle, msb first
  always_comb begin
    r1  = {rem_r, mix_r[63]};
    r1s = (r1 >= {1'b0, top_r}) ? r1 - {1'b0, top_r} : r1;
    r2  = {r1s[COUNT_W-1:0], mix_r[62]};
    r2s = (r2 >= {1'b0, top_r}) ? r2 - {1'b0, top_r} : r2;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read_r <= in_cmd;
      state_r   <= in_seed;
      count_r   <= in_count;
      top_r     <= in_count;
      pos_r     <= in_pos;
      fill_r    <= '0;
    end
    if (cmd.fill_wr) fill_r <= fill_r + 1'b1;
    if (cmd.st_adv) begin
      state_r <= st_new;
      mix_r   <= st_new ^ (st_new >> SHIFT_A);
    end
    if (cmd.mul_clr) begin
      mul_cnt_r <= '0;
      acc_r     <= '0;
    end else if (cmd.mul_step) begin
      mul_cnt_r <= mul_cnt_r + 1'b1;
      if (mul_cnt_r == 2'd0) begin
        acc_r <= prod;
      end else begin
        acc_r[63:32] <= acc_r[63:32] + prod[31:0];
      end
    end
    if (cmd.xs27) mix_r <= acc_r ^ (acc_r >> SHIFT_B);
    if (cmd.xs31) begin
      mix_r     <= acc_r ^ (acc_r >> SHIFT_C);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= r2s[COUNT_W-1:0];
      mix_r     <= mix_r << 2;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.rd_pick) tmp_r <= ram_rd;
    if (cmd.top_dec) top_r <= top_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.commit) valid_count_r <= count_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_err_r   <= is_read_r ? stat.pos_bad : stat.count_bad;
      out_entry_r <= (is_read_r && !stat.pos_bad) ? ENTRY_W'(ram_rd) : '0;
    end
  end

  always_comb begin
    ram_we = cmd.fill_wr | cmd.wr_top | cmd.wr_pick;
    ram_wa = AW'(rem_r);
    ram_wd = tmp_r;
    if (cmd.fill_wr) begin
      ram_wa = AW'(fill_r);
      ram_wd = AW'(fill_r);
    end else if (cmd.wr_top) begin
      ram_wa = AW'(top_r - 1'b1);
      ram_wd = ram_rd;
    end
    ram_re = cmd.rd_top | cmd.rd_pick | cmd.rd_pos;
    ram_ra = AW'(pos_r);
    if (cmd.rd_top) begin
      ram_ra = AW'(top_r - 1'b1);
    end else if (cmd.rd_pick) begin
      ram_ra = AW'(rem_r);
    end
  end

  sis_ram #(.WIDTH(AW), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  always_comb begin
    stat.is_read   = is_read_r;
    stat.pos_bad   = {1'b0, pos_r} >= valid_count_r;
    stat.count_bad = 32'(count_r) > 32'(MAX_ELEMENTS);
    stat.fill_done = fill_r == count_r;
    stat.top_le1   = top_r <= COUNT_W'(1);
    stat.mul_last  = mul_cnt_r == 2'd2;
    stat.div_last  = div_cnt_r == 5'd31;
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_entry = out_entry_r;
  assign out_err   = out_err_r;

endmodule

/* hw/rtl/seeded_index_shuffle_core.sv */
// top level of the seeded fisher-yates index shuffle core
// usage:
//   in channel: one beat per command. in_tuser is the command (0 generate,
//   1 read). generate fills the store with 0..count-1 and shuffles it from
//   the top down, each step drawing splitmix64(seed += golden increment)
//   modulo the remaining count. read returns the entry at a position.
//   out channel: exactly one beat per command. out_tuser is the error flag
//   (count above MAX_ELEMENTS, or read position at or past the generated count).
// steps:
//   generate fills the store, then runs count - 1 shuffle steps for a count
//   of at least 1; each shuffle step is one top check, one state add, three
//   partial products through the shared 32x32 multiplier per 64-bit mix
//   multiply (two of them), the 2-bit-per-cycle modulo unit over all 64 mix
//   bits and a swap through the store's single read and write port.
// one command is in flight at a time; in_tready is high only while idle.
// a finished result waits in the output register while the next command is
// taken; a stalled receiver holds the core in its result state until taken.
// reset clears the generated count, so every read errors until a generate commits a nonzero count.
`timescale 1ns / 1ps
module seeded_index_shuffle_core #(
  parameter int MAX_ELEMENTS = sis_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [63:0] seed_value, [74:64] element_count, [84:75] position, [87:85] zero
  input  logic [sis_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] cmd
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [9:0] entry_value, [15:10] zero
  output logic [sis_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] error_flag
  output logic                               out_tuser
);
  import sis_pkg::*;

  sis_cmd_t           cmd;
  sis_stat_t          stat;
  logic [ENTRY_W-1:0] entry;

  sis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sis_dpath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_cmd    (in_tuser),
    .in_seed   (in_tdata[SEED_W-1:0]),
    .in_count  (in_tdata[SEED_W+COUNT_W-1:SEED_W]),
    .in_pos    (in_tdata[SEED_W+COUNT_W+POS_W-1:SEED_W+COUNT_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_entry (entry),
    .out_err   (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(entry);

endmodule

/* sim/seeded_index_shuffle_core_test.sv */
// testbench for the seeded index shuffle core: predicts each beat and checks every result
`timescale 1ns / 1ps
module seeded_index_shuffle_core_test;
  import sis_pkg::*;

  localparam int MAXN = DEF_MAX_ELEMENTS;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic               err;
  } shuffle_result_t;

  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_READ     = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  // predictor state
  logic [ENTRY_W:0] perm_model [MAXN];
  logic [COUNT_W-1:0] gen_count = '0;
  shuffle_result_t pending_results[$];

  int fail_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  seeded_index_shuffle_core uut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] splitmix_finalize(input logic [63:0] v);
    v = (v ^ (v >> SHIFT_A)) * MIX_MUL_A;
    v = (v ^ (v >> SHIFT_B)) * MIX_MUL_B;
    return v ^ (v >> SHIFT_C);
  endfunction

  function automatic shuffle_result_t predict_command(input logic cmd, input logic [63:0] seed,
                                                      input logic [COUNT_W-1:0] count,
                                                      input logic [POS_W-1:0] pos);
    shuffle_result_t r;
    logic [63:0] st;
    logic [63:0] pick;
    logic [ENTRY_W:0] tmp;
    r = '0;
    if (cmd == CMD_GENERATE) begin
      if (count > MAXN) begin
        r.err = 1'b1;
      end else begin
        for (int i = 0; i < count; i++) perm_model[i] = (ENTRY_W+1)'(i);
        st = seed;
        for (int top = count; top > 1; top--) begin
          st = st + GOLDEN_INC;
          pick = splitmix_finalize(st) % top;
          tmp = perm_model[top-1];
          perm_model[top-1] = perm_model[pick];
          perm_model[pick] = tmp;
        end
        gen_count = count;
      end
    end else if ({1'b0, pos} >= gen_count) begin
      r.err = 1'b1;
    end else begin
      r.entry = perm_model[pos][ENTRY_W-1:0];
    end
    return r;
  endfunction

  task automatic send_command(input logic cmd, input logic [63:0] seed,
                              input logic [COUNT_W-1:0] count, input logic [POS_W-1:0] pos);
    // step past the edge that dropped the previous beat
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {3'b000, pos, count, seed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_command(cmd, seed, count, pos));
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    logic [COUNT_W-1:0] c;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(9))
          0: c = COUNT_W'(MAXN + 1 + $urandom_range(2047 - MAXN - 1));
          1: c = COUNT_W'($urandom_range(200));
          default: c = COUNT_W'($urandom_range(24));
        endcase
        send_command(CMD_GENERATE, {$urandom, $urandom}, c, POS_W'($urandom));
      end else if ($urandom_range(4) == 0) begin
        send_command(CMD_READ, {$urandom, $urandom}, COUNT_W'($urandom), POS_W'($urandom));
      end else begin
        send_command(CMD_READ, {$urandom, $urandom}, COUNT_W'($urandom),
                     gen_count == 0 ? '0 : POS_W'($urandom_range(gen_count)));
      end
    end
  endtask

  task automatic test_directed();
    send_command(CMD_READ, '0, '0, '0);
    send_command(CMD_GENERATE, '1, 11'd1025, '1);
    send_command(CMD_GENERATE, '1, 11'd2047, '0);
    send_command(CMD_GENERATE, '0, '0, '0);
    send_command(CMD_READ, '0, '0, '0);
    send_command(CMD_GENERATE, 64'h0123456789abcdef, 11'd1, '0);
    send_command(CMD_READ, '0, '0, 10'd0);
    send_command(CMD_READ, '0, '0, 10'd1);
    send_command(CMD_GENERATE, '1, 11'd2, '0);
    send_command(CMD_READ, '0, '0, 10'd0);
    send_command(CMD_READ, '0, '0, 10'd1);
    // max count once, pause until it lands
    send_command(CMD_GENERATE, 64'hdeadbeefcafef00d, 11'd1024, '0);
    drain_results();
    send_command(CMD_READ, '1, '1, 10'd1023);
    send_command(CMD_READ, '0, '0, 10'd0);
    send_command(CMD_READ, '0, '0, 10'd512);
    send_command(CMD_GENERATE, '0, 11'd1025, '0);
    send_command(CMD_READ, '0, '0, 10'd1023);
    send_command(CMD_GENERATE, '0, 11'd7, '0);
    send_command(CMD_READ, '0, '0, 10'd6);
    send_command(CMD_READ, '0, '0, 10'd7);
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0; recv_stall_pct = 0;
    run_random(25);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 68; recv_stall_pct = 0;
    run_random(25);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0; recv_stall_pct = 68;
    run_random(25);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 8; recv_stall_pct = 8;
    run_random(25);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    shuffle_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result entry=%0d err=%0b", $time,
                 out_tdata[ENTRY_W-1:0], out_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== {6'b0, want.entry}) begin
          $display("%0t: entry mismatch expected %0d actual %0d", $time, want.entry, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.err) begin
          $display("%0t: error flag mismatch expected %0b actual %0b", $time, want.err,
                   out_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("seeded_index_shuffle_core_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    drain_results();
    if (fail_count == 0) begin
      $display("seeded_index_shuffle_core_test: PASS");
    end else begin
      $display("seeded_index_shuffle_core_test: FAIL");
    end
    $finish;
  end
endmodule

/* files.f */
hw/rtl/sis_pkg.sv
hw/rtl/sis_ram.sv
hw/rtl/sis_ctrl.sv
hw/rtl/sis_dpath.sv
hw/rtl/seeded_index_shuffle_core.sv
sim/seeded_index_shuffle_core_test.sv
